@@ sv/ffra_pkg.sv @@
`timescale 1ns / 1ps

package ffra_pkg;

    localparam int MAX_CHUNKS       = 64;
    localparam int HEADER_BYTES     = 16;
    localparam int GRANULE_BYTES    = 16;
    localparam int REGION_ADDR_BITS = 24;

    localparam int IDX_W   = $clog2(MAX_CHUNKS);
    localparam int CNT_W   = $clog2(MAX_CHUNKS + 1);
    localparam int PAY_W   = REGION_ADDR_BITS;
    localparam int SIZE_W  = 25;
    localparam int BYTES_W = 25;
    localparam int ADDR_W  = 32;
    localparam int NEED_W  = SIZE_W + 1;
    localparam int OFF_W   = REGION_ADDR_BITS + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [BYTES_W-1:0] REGION_LIMIT = BYTES_W'(1) << REGION_ADDR_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION = 1'b1;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_ZERO,
        ST_NOSPACE,
        ST_FULL,
        ST_NOTFOUND,
        ST_ALREADY
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_CHK,
        S_SHR,
        S_SHW,
        S_SPLO,
        S_SPHI,
        S_MERGE,
        S_SLR,
        S_SLW,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_JM1,
        RD_IDXP1,
        RD_JPS
    } rd_sel_t;

    typedef struct packed {
        logic    start;
        rd_sel_t rd_sel;
        logic    load_cur;
        logic    step;
        logic    split_init;
        logic    sh_write;
        logic    split_lo;
        logic    split_hi;
        logic    whole;
        logic    merge;
        logic    sl_write;
        logic    result;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic size_zero;
        logic table_empty;
        logic is_release;
        logic fit;
        logic split_needed;
        logic table_full;
        logic last;
        logic addr_hit;
        logic cur_busy;
        logic has_next;
        logic sh_more;
        logic merge_none;
        logic sl_done;
        logic out_busy;
    } sts_t;

endpackage

@@ sv/ffra_req_if.sv @@
`timescale 1ns / 1ps

interface ffra_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [ffra_pkg::SIZE_W-1:0]   request_size;
    logic [ffra_pkg::ADDR_W-1:0]   address;

    modport source (output valid, operation, request_size, address, input ready);
    modport sink (input valid, operation, request_size, address, output ready);
endinterface

@@ sv/ffra_rsp_if.sv @@
`timescale 1ns / 1ps

interface ffra_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [ffra_pkg::ADDR_W-1:0]   granted_address;
    logic [ffra_pkg::BYTES_W-1:0]  used_size;
    logic [ffra_pkg::BYTES_W-1:0]  free_size;
    logic [ffra_pkg::BYTES_W-1:0]  total_size;

    modport source (output valid, status, granted_address, used_size, free_size,
                    total_size, input ready);
    modport sink (input valid, status, granted_address, used_size, free_size,
                  total_size, output ready);
endinterface

@@ sv/ffra_cfg_if.sv @@
`timescale 1ns / 1ps

interface ffra_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ffra_pkg::CFG_IDX_W-1:0]   index;
    logic [ffra_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/ffra_ctrl.sv @@
`timescale 1ns / 1ps

module ffra_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ffra_pkg::sts_t sts,
    output ffra_pkg::cmd_t cmd
);

    ffra_pkg::state_t  state_reg, state_next;
    ffra_pkg::status_t st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ffra_pkg::S_IDLE;
            st_reg    <= ffra_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        st_next    = st_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        cmd.rd_sel = ffra_pkg::RD_NONE;
        cmd.status = st_reg;
        case (state_reg)
            ffra_pkg::S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ffra_pkg::S_START;
                end
            end
            ffra_pkg::S_START: begin
                if (!sts.is_release && sts.size_zero) begin
                    st_next    = ffra_pkg::ST_ZERO;
                    state_next = ffra_pkg::S_DONE;
                end else if (sts.table_empty) begin
                    st_next    = sts.is_release ? ffra_pkg::ST_NOTFOUND : ffra_pkg::ST_NOSPACE;
                    state_next = ffra_pkg::S_DONE;
                end else begin
                    state_next = ffra_pkg::S_RD;
                end
            end
            ffra_pkg::S_RD: begin
                cmd.rd_sel = ffra_pkg::RD_IDX;
                state_next = ffra_pkg::S_CHK;
            end
            ffra_pkg::S_CHK: begin
                cmd.load_cur = 1'b1;
                if (!sts.is_release) begin
                    if (sts.fit) begin
                        if (sts.split_needed) begin
                            if (sts.table_full) begin
                                st_next    = ffra_pkg::ST_FULL;
                                state_next = ffra_pkg::S_DONE;
                            end else begin
                                cmd.split_init = 1'b1;
                                state_next     = ffra_pkg::S_SHR;
                            end
                        end else begin
                            cmd.whole  = 1'b1;
                            st_next    = ffra_pkg::ST_OK;
                            state_next = ffra_pkg::S_DONE;
                        end
                    end else if (sts.last) begin
                        st_next    = ffra_pkg::ST_NOSPACE;
                        state_next = ffra_pkg::S_DONE;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = ffra_pkg::S_RD;
                    end
                end else begin
                    if (sts.addr_hit) begin
                        if (!sts.cur_busy) begin
                            st_next    = ffra_pkg::ST_ALREADY;
                            state_next = ffra_pkg::S_DONE;
                        end else begin
                            if (sts.has_next) begin
                                cmd.rd_sel = ffra_pkg::RD_IDXP1;
                            end
                            state_next = ffra_pkg::S_MERGE;
                        end
                    end else if (sts.last) begin
                        st_next    = ffra_pkg::ST_NOTFOUND;
                        state_next = ffra_pkg::S_DONE;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = ffra_pkg::S_RD;
                    end
                end
            end
            ffra_pkg::S_SHR: begin
                if (sts.sh_more) begin
                    cmd.rd_sel = ffra_pkg::RD_JM1;
                    state_next = ffra_pkg::S_SHW;
                end else begin
                    state_next = ffra_pkg::S_SPLO;
                end
            end
            ffra_pkg::S_SHW: begin
                cmd.sh_write = 1'b1;
                state_next   = ffra_pkg::S_SHR;
            end
            ffra_pkg::S_SPLO: begin
                cmd.split_lo = 1'b1;
                state_next   = ffra_pkg::S_SPHI;
            end
            ffra_pkg::S_SPHI: begin
                cmd.split_hi = 1'b1;
                st_next      = ffra_pkg::ST_OK;
                state_next   = ffra_pkg::S_DONE;
            end
            ffra_pkg::S_MERGE: begin
                cmd.merge = 1'b1;
                st_next   = ffra_pkg::ST_OK;
                state_next = sts.merge_none ? ffra_pkg::S_DONE : ffra_pkg::S_SLR;
            end
            ffra_pkg::S_SLR: begin
                if (sts.sl_done) begin
                    state_next = ffra_pkg::S_DONE;
                end else begin
                    cmd.rd_sel = ffra_pkg::RD_JPS;
                    state_next = ffra_pkg::S_SLW;
                end
            end
            ffra_pkg::S_SLW: begin
                cmd.sl_write = 1'b1;
                state_next   = ffra_pkg::S_SLR;
            end
            ffra_pkg::S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.result = 1'b1;
                    state_next = ffra_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ffra_pkg::S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/ffra_dp.sv @@
`timescale 1ns / 1ps

module ffra_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ffra_pkg::cmd_t                    cmd,
    output ffra_pkg::sts_t                    sts,
    input  logic                              operation,
    input  logic [ffra_pkg::SIZE_W-1:0]       request_size,
    input  logic [ffra_pkg::ADDR_W-1:0]       address,
    input  logic                              cfg_valid,
    input  logic [ffra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ffra_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              out_ready,
    output logic                              out_valid,
    output ffra_pkg::status_t                 status,
    output logic [ffra_pkg::ADDR_W-1:0]       granted_address,
    output logic [ffra_pkg::BYTES_W-1:0]      used_size,
    output logic [ffra_pkg::BYTES_W-1:0]      free_size,
    output logic [ffra_pkg::BYTES_W-1:0]      total_size
);

    localparam int IW = ffra_pkg::IDX_W;
    localparam int CW = ffra_pkg::CNT_W;
    localparam int PW = ffra_pkg::PAY_W;
    localparam int BW = ffra_pkg::BYTES_W;
    localparam int NW = ffra_pkg::NEED_W;
    localparam int OW = ffra_pkg::OFF_W;
    localparam int AW = ffra_pkg::ADDR_W;

    logic [PW:0] mem [ffra_pkg::MAX_CHUNKS];

    logic [AW-1:0] base_reg;
    logic [BW-1:0] eff_reg;
    logic [CW-1:0] total_reg;
    logic [BW-1:0] used_reg;
    logic [BW-1:0] free_reg;
    logic          init_reg;
    logic          out_valid_reg;

    logic                         op_reg;
    logic [ffra_pkg::SIZE_W-1:0]  size_reg;
    logic [AW-1:0]                addr_reg;
    logic [OW-1:0]                off_reg;
    logic [IW-1:0]                idx_reg;
    logic [CW-1:0]                j_reg;
    logic [1:0]                   s_reg;
    logic [PW-1:0]                cur_pay_reg;
    logic                         prev_busy_reg;
    logic [PW-1:0]                prev_pay_reg;
    logic [PW:0]                  mem_q_reg;
    logic                         rd0_reg;
    logic [AW-1:0]                grant_reg;
    ffra_pkg::status_t            status_reg;
    logic [AW-1:0]                granted_out_reg;
    logic [BW-1:0]                used_out_reg;
    logic [BW-1:0]                free_out_reg;
    logic [BW-1:0]                total_out_reg;

    logic          rd_busy;
    logic [PW-1:0] rd_pay;
    logic [NW-1:0] need;
    logic [CW-1:0] idx_p1;
    logic          rd_en;
    logic [IW-1:0] raddr;
    logic          wr_en;
    logic [IW-1:0] waddr;
    logic [PW:0]   wdata;
    logic          pm;
    logic          nm;
    logic [1:0]    s_next;
    logic [BW-1:0] mval;
    logic [IW-1:0] mw;
    logic [CW-1:0] md;
    logic [BW-1:0] cfg_eff;
    logic [AW-1:0] chunk_addr;

    assign rd_busy = rd0_reg ? 1'b0 : mem_q_reg[PW];
    assign rd_pay  = rd0_reg ? PW'(eff_reg - BW'(ffra_pkg::HEADER_BYTES)) : mem_q_reg[PW-1:0];

    assign need = NW'((NW'(size_reg) + NW'(ffra_pkg::GRANULE_BYTES - 1))
                      / ffra_pkg::GRANULE_BYTES * ffra_pkg::GRANULE_BYTES);
    assign idx_p1     = CW'(idx_reg) + CW'(1);
    assign chunk_addr = base_reg + AW'(off_reg) + AW'(ffra_pkg::HEADER_BYTES);

    assign cfg_eff = (cfg_data[BW-1:0] > ffra_pkg::REGION_LIMIT)
                     ? ffra_pkg::REGION_LIMIT : cfg_data[BW-1:0];

    always_comb begin
        pm     = (idx_reg != '0) && !prev_busy_reg;
        nm     = (idx_p1 < total_reg) && !rd_busy;
        s_next = {1'b0, pm} + {1'b0, nm};
        mval   = BW'(cur_pay_reg);
        if (pm) begin
            mval = mval + BW'(prev_pay_reg) + BW'(ffra_pkg::HEADER_BYTES);
        end
        if (nm) begin
            mval = mval + BW'(rd_pay) + BW'(ffra_pkg::HEADER_BYTES);
        end
        mw = pm ? idx_reg - IW'(1) : idx_reg;
        md = pm ? CW'(idx_reg) : idx_p1;
    end

    always_comb begin
        sts              = '0;
        sts.size_zero    = (size_reg == '0);
        sts.table_empty  = (total_reg == '0);
        sts.is_release   = (op_reg == ffra_pkg::OP_RELEASE);
        sts.fit          = !rd_busy && (NW'(rd_pay) >= need);
        sts.split_needed = NW'(rd_pay) > need + NW'(ffra_pkg::HEADER_BYTES);
        sts.table_full   = total_reg >= CW'(ffra_pkg::MAX_CHUNKS);
        sts.last         = (idx_p1 == total_reg);
        sts.addr_hit     = (chunk_addr == addr_reg);
        sts.cur_busy     = rd_busy;
        sts.has_next     = (idx_p1 < total_reg);
        sts.sh_more      = (j_reg > idx_p1);
        sts.merge_none   = (s_next == 2'd0);
        sts.sl_done      = (j_reg >= total_reg);
        sts.out_busy     = out_valid_reg && !out_ready;
    end

    always_comb begin
        rd_en = 1'b1;
        case (cmd.rd_sel)
            ffra_pkg::RD_IDX:   raddr = idx_reg;
            ffra_pkg::RD_JM1:   raddr = IW'(j_reg - CW'(1));
            ffra_pkg::RD_IDXP1: raddr = IW'(idx_p1);
            ffra_pkg::RD_JPS:   raddr = IW'(j_reg + CW'(s_reg));
            default: begin
                rd_en = 1'b0;
                raddr = idx_reg;
            end
        endcase
    end

    always_comb begin
        wr_en = 1'b1;
        waddr = idx_reg;
        wdata = {rd_busy, rd_pay};
        if (cmd.whole) begin
            wdata = {1'b1, rd_pay};
        end else if (cmd.sh_write || cmd.sl_write) begin
            waddr = IW'(j_reg);
        end else if (cmd.split_lo) begin
            waddr = IW'(idx_p1);
            wdata = {1'b0, PW'(NW'(cur_pay_reg) - need - NW'(ffra_pkg::HEADER_BYTES))};
        end else if (cmd.split_hi) begin
            wdata = {1'b1, PW'(need)};
        end else if (cmd.merge) begin
            waddr = mw;
            wdata = {1'b0, PW'(mval)};
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            mem_q_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            base_reg      <= 32'h0800_0000;
            eff_reg       <= ffra_pkg::REGION_LIMIT;
            total_reg     <= CW'(1);
            used_reg      <= '0;
            free_reg      <= ffra_pkg::REGION_LIMIT - BW'(ffra_pkg::HEADER_BYTES);
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == ffra_pkg::CFG_BASE) begin
                    base_reg <= cfg_data;
                end else begin
                    eff_reg  <= cfg_eff;
                    used_reg <= '0;
                    init_reg <= 1'b1;
                    if (cfg_eff > BW'(ffra_pkg::HEADER_BYTES)) begin
                        total_reg <= CW'(1);
                        free_reg  <= cfg_eff - BW'(ffra_pkg::HEADER_BYTES);
                    end else begin
                        total_reg <= '0;
                        free_reg  <= '0;
                    end
                end
            end
            if (wr_en && waddr == '0) begin
                init_reg <= 1'b0;
            end
            if (cmd.whole) begin
                used_reg <= used_reg + BW'(rd_pay);
                free_reg <= free_reg - BW'(rd_pay);
            end
            if (cmd.split_hi) begin
                total_reg <= total_reg + CW'(1);
                used_reg  <= used_reg + BW'(need);
                free_reg  <= free_reg - BW'(need) - BW'(ffra_pkg::HEADER_BYTES);
            end
            if (cmd.merge) begin
                total_reg <= total_reg - CW'(s_next);
                used_reg  <= used_reg - BW'(cur_pay_reg);
                free_reg  <= free_reg + BW'(cur_pay_reg)
                             + BW'(s_next) * BW'(ffra_pkg::HEADER_BYTES);
            end
            if (cmd.result) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd0_reg <= init_reg && (raddr == '0);
        end
        if (cmd.start) begin
            op_reg        <= operation;
            size_reg      <= request_size;
            addr_reg      <= address;
            off_reg       <= '0;
            idx_reg       <= '0;
            prev_busy_reg <= 1'b1;
            grant_reg     <= '0;
        end
        if (cmd.load_cur) begin
            cur_pay_reg <= rd_pay;
        end
        if (cmd.step) begin
            off_reg       <= off_reg + OW'(ffra_pkg::HEADER_BYTES) + OW'(rd_pay);
            prev_busy_reg <= rd_busy;
            prev_pay_reg  <= rd_pay;
            idx_reg       <= idx_reg + IW'(1);
        end
        if (cmd.split_init) begin
            j_reg <= total_reg;
        end
        if (cmd.sh_write) begin
            j_reg <= j_reg - CW'(1);
        end
        if (cmd.whole || cmd.split_hi) begin
            grant_reg <= chunk_addr;
        end
        if (cmd.merge) begin
            j_reg <= md;
            s_reg <= s_next;
        end
        if (cmd.sl_write) begin
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.result) begin
            status_reg      <= cmd.status;
            granted_out_reg <= grant_reg;
            used_out_reg    <= used_reg;
            free_out_reg    <= free_reg;
            total_out_reg   <= (total_reg != '0) ? eff_reg : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign granted_address = granted_out_reg;
    assign used_size       = used_out_reg;
    assign free_size       = free_out_reg;
    assign total_size      = total_out_reg;

endmodule

@@ sv/first_fit_region_allocator.sv @@
`timescale 1ns / 1ps

// First-fit allocator for one bus region, kept as an address-ordered table of up to
// 64 chunks in a single-port-write, registered-read memory. A request walks the table
// from the first chunk; each entry visited is first read and then examined. A split
// then moves every later entry up by one and a merging release moves later entries
// down, each moved entry again being read and then written. A new request is taken
// only when the previous one is finished; its result sits in an output register until
// taken. Configuration beats are always accepted and must arrive while the block is
// idle; writing region_bytes resets the table to one free chunk at once, or to an
// empty table if the region is no larger than one chunk header.
module first_fit_region_allocator (
    input logic        clk,
    input logic        rst_n,
    ffra_req_if.sink   req,
    ffra_rsp_if.source rsp,
    ffra_cfg_if.sink   cfg
);

    ffra_pkg::cmd_t    cmd;
    ffra_pkg::sts_t    sts;
    ffra_pkg::status_t status;
    logic              ready;

    ffra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffra_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .operation       (req.operation),
        .request_size    (req.request_size),
        .address         (req.address),
        .cfg_valid       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .status          (status),
        .granted_address (rsp.granted_address),
        .used_size       (rsp.used_size),
        .free_size       (rsp.free_size),
        .total_size      (rsp.total_size)
    );

    assign req.ready  = ready;
    assign rsp.status = status;
    assign cfg.ready  = 1'b1;

endmodule

@@ sim/first_fit_region_allocator_tb.sv @@
`timescale 1ns / 1ps

module first_fit_region_allocator_tb;
    import ffra_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   granted_address;
        logic [BYTES_W-1:0]  used_size;
        logic [BYTES_W-1:0]  free_size;
        logic [BYTES_W-1:0]  total_size;
    } outcome_t;

    class heap_scoreboard;
        logic [ADDR_W-1:0]  base_addr;
        logic [BYTES_W-1:0] region_len;
        logic [PAY_W:0]     payload [MAX_CHUNKS];
        bit                 busy [MAX_CHUNKS];
        int                 chunk_count;
        outcome_t           pending [$];
        int                 mismatches;
        logic [ADDR_W-1:0]  live_addrs [$];

        function void rebuild();
            logic [BYTES_W-1:0] eff;
            eff = (region_len > REGION_LIMIT) ? REGION_LIMIT : region_len;
            for (int i = 0; i < MAX_CHUNKS; i++)
            begin
                payload[i] = '0;
                busy[i] = 1'b0;
            end
            live_addrs.delete();
            if (eff > HEADER_BYTES)
            begin
                payload[0] = eff - HEADER_BYTES;
                chunk_count = 1;
            end
            else
                chunk_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_BASE)
            begin
                base_addr = value;
                live_addrs.delete();
            end
            else
            begin
                region_len = value[BYTES_W-1:0];
                rebuild();
            end
        endfunction

        function logic [ADDR_W-1:0] user_addr(longint off);
            return ADDR_W'(longint'(base_addr) + off + HEADER_BYTES);
        endfunction

        function void drop_entry(int idx);
            for (int k = idx; k + 1 < chunk_count; k++)
            begin
                payload[k] = payload[k + 1];
                busy[k] = busy[k + 1];
            end
            chunk_count--;
        endfunction

        function status_t allocate(logic [SIZE_W-1:0] size, output logic [ADDR_W-1:0] grant);
            longint need;
            longint off;
            grant = '0;
            off = 0;
            if (size == 0)
                return ST_ZERO;
            need = ((longint'(size) + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
            for (int i = 0; i < chunk_count; i++)
            begin
                if (!busy[i] && payload[i] >= need)
                begin
                    if (payload[i] > need + HEADER_BYTES)
                    begin
                        if (chunk_count >= MAX_CHUNKS)
                            return ST_FULL;
                        for (int k = chunk_count; k > i + 1; k--)
                        begin
                            payload[k] = payload[k - 1];
                            busy[k] = busy[k - 1];
                        end
                        payload[i + 1] = payload[i] - need - HEADER_BYTES;
                        busy[i + 1] = 1'b0;
                        payload[i] = need;
                        chunk_count++;
                    end
                    busy[i] = 1'b1;
                    grant = user_addr(off);
                    return ST_OK;
                end
                off += HEADER_BYTES + payload[i];
            end
            return ST_NOSPACE;
        endfunction

        function status_t release_chunk(logic [ADDR_W-1:0] addr);
            longint off;
            int hit;
            off = 0;
            hit = -1;
            for (int i = 0; i < chunk_count; i++)
            begin
                if (user_addr(off) == addr)
                begin
                    hit = i;
                    break;
                end
                off += HEADER_BYTES + payload[i];
            end
            if (hit < 0)
                return ST_NOTFOUND;
            if (!busy[hit])
                return ST_ALREADY;
            busy[hit] = 1'b0;
            if (hit > 0 && !busy[hit - 1])
            begin
                payload[hit - 1] += payload[hit] + HEADER_BYTES;
                drop_entry(hit);
                hit--;
            end
            if (hit + 1 < chunk_count && !busy[hit + 1])
            begin
                payload[hit] += payload[hit + 1] + HEADER_BYTES;
                drop_entry(hit + 1);
            end
            return ST_OK;
        endfunction

        function void note_request(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
            outcome_t o;
            longint used_sum;
            longint free_sum;
            longint all_sum;
            logic [ADDR_W-1:0] g;
            g = '0;
            used_sum = 0;
            free_sum = 0;
            all_sum = 0;
            if (op == OP_RELEASE)
            begin
                o.status = release_chunk(addr);
                if (o.status == ST_OK)
                    foreach (live_addrs[i])
                        if (live_addrs[i] == addr)
                        begin
                            live_addrs.delete(i);
                            break;
                        end
            end
            else
            begin
                o.status = allocate(size, g);
                if (o.status == ST_OK)
                    live_addrs.push_back(g);
            end
            for (int i = 0; i < chunk_count; i++)
            begin
                all_sum += HEADER_BYTES + payload[i];
                if (busy[i])
                    used_sum += payload[i];
                else
                    free_sum += payload[i];
            end
            o.granted_address = g;
            o.used_size = BYTES_W'(used_sum);
            o.free_size = BYTES_W'(free_sum);
            o.total_size = BYTES_W'(all_sum);
            pending.push_back(o);
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.granted_address !== want.granted_address ||
                got.used_size !== want.used_size || got.free_size !== want.free_size ||
                got.total_size !== want.total_size)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ffra_req_if req ();
    ffra_rsp_if rsp ();
    ffra_cfg_if cfg ();

    first_fit_region_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    heap_scoreboard board;
    int  idle_cycles;
    bit  hold_off;
    bit  stall_enable;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            board.note_request(req.operation, req.request_size, req.address);
        if (rst_n && rsp.valid && rsp.ready)
            board.check_result({status_t'(rsp.status), rsp.granted_address, rsp.used_size,
                                rsp.free_size, rsp.total_size});
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_off)
            rsp.ready <= 1'b0;
        else if (stall_enable)
            rsp.ready <= ($urandom_range(0, 3) != 0);
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        board.write_reg(idx, value);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_request(logic op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        req.valid <= 1'b1;
        req.operation <= op;
        req.request_size <= size;
        req.address <= addr;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic pause_sender();
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 12))
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic random_request();
        int pick;
        logic [SIZE_W-1:0] size;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            if ($urandom_range(0, 9) == 0)
                size = SIZE_W'($urandom);
            else
                size = SIZE_W'($urandom_range(1, 600));
            send_request(OP_ALLOC, size, $urandom);
        end
        else if (pick < 85 && board.live_addrs.size() != 0)
            send_request(OP_RELEASE, SIZE_W'($urandom),
                         board.live_addrs[$urandom_range(0, board.live_addrs.size() - 1)]);
        else if (pick < 92)
            send_request(OP_RELEASE, SIZE_W'($urandom), $urandom);
        else
            send_request(OP_RELEASE, SIZE_W'($urandom), board.base_addr + HEADER_BYTES);
    endtask

    task automatic random_phase(int count, bit bursty);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            random_request();
            if (bursty)
            begin
                if (burst == 0)
                begin
                    pause_sender();
                    burst = $urandom_range(1, 10);
                end
                else
                    burst--;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        logic [ADDR_W-1:0] g1;
        board = new();
        board.base_addr = 32'h0800_0000;
        board.region_len = 25'h100_0000;
        board.rebuild();
        board.mismatches = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        stall_enable = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_ALLOC;
        req.request_size = '0;
        req.address = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_BASE;
        cfg.data = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_ALLOC, 0, '0);
        send_request(OP_ALLOC, 1, '0);
        g1 = 32'h0800_0000 + HEADER_BYTES;
        send_request(OP_ALLOC, 25'h1FF_FFFF, '0);
        send_request(OP_ALLOC, 25'h100_0000, '0);
        send_request(OP_RELEASE, '0, g1);
        send_request(OP_RELEASE, '0, g1);
        send_request(OP_RELEASE, '0, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, SIZE_W'(25'h0FF_FFF0 - 32), '0);
        send_request(OP_ALLOC, 16, '0);
        send_request(OP_RELEASE, '0, g1);
        send_request(OP_RELEASE, '0, g1 + 25'h0FF_FFD0 + HEADER_BYTES);
        wait_drained();

        write_config(CFG_BASE, 32'hFFFF_FFF0);
        write_config(CFG_REGION, 25'h1FF_FFFF);
        send_request(OP_ALLOC, 17, '0);
        send_request(OP_ALLOC, 1, '0);
        send_request(OP_RELEASE, '0, 32'h0000_0000);
        send_request(OP_RELEASE, '0, 32'h0000_0020);
        wait_drained();

        write_config(CFG_REGION, 16);
        send_request(OP_ALLOC, 1, '0);
        send_request(OP_RELEASE, '0, 32'hFFFF_FFF0 + HEADER_BYTES);
        wait_drained();
        write_config(CFG_REGION, 0);
        send_request(OP_ALLOC, 5, '0);
        wait_drained();

        write_config(CFG_BASE, 32'h0000_0000);
        write_config(CFG_REGION, 25'h000_4000);
        for (int n = 0; n < 70; n++)
            send_request(OP_ALLOC, 16, '0);
        wait_drained();

        stall_enable = 1'b1;
        write_config(CFG_BASE, $urandom);
        write_config(CFG_REGION, 25'h000_2000);
        fork
            begin
                repeat (50)
                    @(posedge clk);
                hold_off = 1'b1;
                repeat (3000)
                    @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(40, 1'b0);
        join
        random_phase(500, 1'b1);

        write_config(CFG_BASE, 32'hFFFF_F000);
        write_config(CFG_REGION, 25'h000_1800);
        stall_enable = 1'b0;
        random_phase(300, 1'b0);

        stall_enable = 1'b1;
        write_config(CFG_REGION, $urandom_range(0, 25'h200_0000));
        random_phase(200, 1'b1);
        write_config(CFG_BASE, $urandom);
        write_config(CFG_REGION, 25'h000_0800);
        random_phase(420, 1'b1);

        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ files.f @@
sv/ffra_pkg.sv
sv/ffra_req_if.sv
sv/ffra_rsp_if.sv
sv/ffra_cfg_if.sv
sv/ffra_ctrl.sv
sv/ffra_dp.sv
sv/first_fit_region_allocator.sv
sim/first_fit_region_allocator_tb.sv
